[hw/rtl/pu_pkg.sv]
// ---------------------------------------------------------------------------
// pu_pkg
// Shared types and constants for the permutation unrank unit: factorial
// table, controller states and the command/status bundles.
// ---------------------------------------------------------------------------
package pu_pkg;

    localparam int SIZE_W = 5;
    localparam int RANK_W = 62;
    localparam int ELEM_W = 5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV
    } state_t;

    typedef struct packed {
        logic load;
        logic check;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic bad;
        logic bit_last;
        logic digit_last;
    } status_t;

    // n! for n = 0..20; larger indexes give zero
    function automatic logic [RANK_W-1:0] fact(input logic [SIZE_W-1:0] n);
        logic [RANK_W-1:0] f;
        case (n)
            5'd0:    f = 62'd1;
            5'd1:    f = 62'd1;
            5'd2:    f = 62'd2;
            5'd3:    f = 62'd6;
            5'd4:    f = 62'd24;
            5'd5:    f = 62'd120;
            5'd6:    f = 62'd720;
            5'd7:    f = 62'd5040;
            5'd8:    f = 62'd40320;
            5'd9:    f = 62'd362880;
            5'd10:   f = 62'd3628800;
            5'd11:   f = 62'd39916800;
            5'd12:   f = 62'd479001600;
            5'd13:   f = 62'd6227020800;
            5'd14:   f = 62'd87178291200;
            5'd15:   f = 62'd1307674368000;
            5'd16:   f = 62'd20922789888000;
            5'd17:   f = 62'd355687428096000;
            5'd18:   f = 62'd6402373705728000;
            5'd19:   f = 62'd121645100408832000;
            5'd20:   f = 62'd2432902008176640000;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

[hw/rtl/pu_ctrl.sv]
// ---------------------------------------------------------------------------
// pu_ctrl
// Controller: sequences request check and the per-digit division steps.
// ---------------------------------------------------------------------------
module pu_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  pu_pkg::status_t status,
    output pu_pkg::cmd_t    cmd,
    output logic            busy
);

    pu_pkg::state_t state_reg;
    pu_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pu_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pu_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = pu_pkg::ST_CHECK;
                end
            end
            pu_pkg::ST_CHECK:
            begin
                state_next = status.bad ? pu_pkg::ST_IDLE : pu_pkg::ST_DIV;
            end
            pu_pkg::ST_DIV:
            begin
                if (status.bit_last && status.digit_last)
                begin
                    state_next = pu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pu_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            pu_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            pu_pkg::ST_CHECK:
            begin
                cmd.check = 1'b1;
            end
            pu_pkg::ST_DIV:
            begin
                cmd.step = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

[hw/rtl/pu_datapath.sv]
// ---------------------------------------------------------------------------
// pu_datapath
// Rank register, restoring divider (one quotient bit per cycle), pool of
// unused values and the result registers.
// ---------------------------------------------------------------------------
module pu_datapath #(
    parameter int MAX_SIZE = 20
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pu_pkg::cmd_t                cmd,
    output pu_pkg::status_t             status,
    input  logic [pu_pkg::SIZE_W-1:0]   size,
    input  logic [pu_pkg::RANK_W-1:0]   rank,
    output logic                        strobe,
    output logic [pu_pkg::ELEM_W-1:0]   element,
    output logic                        last,
    output logic                        error
);

    localparam int QW = $clog2(MAX_SIZE);
    localparam int LW = $clog2(MAX_SIZE + 1);
    localparam int BW = $clog2(QW + 1);
    localparam int DW = pu_pkg::RANK_W + QW - 1;

    logic [pu_pkg::SIZE_W-1:0] size_reg;
    logic [pu_pkg::RANK_W-1:0] rank_reg;
    logic [pu_pkg::RANK_W-1:0] rank_next;
    logic [DW-1:0]             div_reg;
    logic [DW-1:0]             div_next;
    logic [LW-1:0]             left_reg;
    logic [LW-1:0]             left_next;
    logic [BW-1:0]             bit_reg;
    logic [BW-1:0]             bit_next;
    logic [QW-1:0]             q_reg;
    logic [QW-1:0]             q_next;
    logic [pu_pkg::ELEM_W-1:0] pool_reg [MAX_SIZE];
    logic [pu_pkg::ELEM_W-1:0] pool_next [MAX_SIZE];

    logic                      strobe_reg;
    logic                      strobe_next;
    logic [pu_pkg::ELEM_W-1:0] element_reg;
    logic [pu_pkg::ELEM_W-1:0] element_next;
    logic                      last_reg;
    logic                      last_next;
    logic                      error_reg;
    logic                      error_next;

    logic                      ge;
    logic [QW-1:0]             q_full;
    logic [QW-1:0]             pos;
    logic [LW-1:0]             left_m1;
    logic [LW-1:0]             left_m2;
    logic [pu_pkg::SIZE_W-1:0] size_m1;
    logic                      bad;

    assign ge      = {{(QW-1){1'b0}}, rank_reg} >= div_reg;
    assign q_full  = q_reg | (ge ? QW'(1) : QW'(0));
    assign left_m1 = left_reg - LW'(1);
    assign left_m2 = left_reg - LW'(2);
    assign size_m1 = size_reg - pu_pkg::SIZE_W'(1);
    // clamp only matters for an out-of-range rank, which is filtered earlier
    assign pos     = (LW'(q_full) >= left_reg) ? left_m1[QW-1:0] : q_full;

    assign bad = (size_reg == '0) || (size_reg > pu_pkg::SIZE_W'(MAX_SIZE))
                 || (rank_reg >= pu_pkg::fact(size_reg));

    assign status.bad        = bad;
    assign status.bit_last   = (bit_reg == '0);
    assign status.digit_last = (left_reg == LW'(1));

    always_comb
    begin
        rank_next    = rank_reg;
        div_next     = div_reg;
        left_next    = left_reg;
        bit_next     = bit_reg;
        q_next       = q_reg;
        pool_next    = pool_reg;
        strobe_next  = 1'b0;
        element_next = element_reg;
        last_next    = last_reg;
        error_next   = error_reg;

        if (cmd.check)
        begin
            if (bad)
            begin
                strobe_next  = 1'b1;
                element_next = '0;
                last_next    = 1'b1;
                error_next   = 1'b1;
            end
            left_next = size_reg[LW-1:0];
            div_next  = DW'(pu_pkg::fact(size_m1)) << (QW - 1);
            bit_next  = BW'(QW - 1);
            q_next    = '0;
            for (int j = 0; j < MAX_SIZE; j++)
            begin
                pool_next[j] = pu_pkg::ELEM_W'(j);
            end
        end

        if (cmd.step)
        begin
            if (ge)
            begin
                rank_next = rank_reg - div_reg[pu_pkg::RANK_W-1:0];
            end
            if (bit_reg == '0)
            begin
                // digit done: emit and drop the chosen value from the pool
                strobe_next  = 1'b1;
                element_next = pool_reg[pos];
                last_next    = (left_reg == LW'(1));
                error_next   = 1'b0;
                for (int j = 0; j < MAX_SIZE - 1; j++)
                begin
                    if (QW'(j) >= pos)
                    begin
                        pool_next[j] = pool_reg[j + 1];
                    end
                end
                left_next = left_m1;
                div_next  = DW'(pu_pkg::fact(pu_pkg::SIZE_W'(left_m2))) << (QW - 1);
                bit_next  = BW'(QW - 1);
                q_next    = '0;
            end
            else
            begin
                q_next   = q_full << 1;
                div_next = div_reg >> 1;
                bit_next = bit_reg - BW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            size_reg <= size;
            rank_reg <= rank;
        end
        else
        begin
            rank_reg <= rank_next;
        end
        div_reg     <= div_next;
        left_reg    <= left_next;
        bit_reg     <= bit_next;
        q_reg       <= q_next;
        pool_reg    <= pool_next;
        element_reg <= element_next;
        last_reg    <= last_next;
        error_reg   <= error_next;
    end

    assign strobe  = strobe_reg;
    assign element = element_reg;
    assign last    = last_reg;
    assign error   = error_reg;

endmodule

[hw/rtl/permutation_unrank_unit.sv]
// ---------------------------------------------------------------------------
// permutation_unrank_unit
// Lehmer-code unranking: emits the permutation of 0..size-1 with the given
// lexicographic rank, one element per result, last one marked.
//
//   channel   handshake      payload
//   request   start / busy   size, rank
//   result    strobe         element, last, error
//
// A request is taken when start is high and busy is low. The check state then
// tests it; a rejected request gives its single error result right after.
// Each element then needs clog2(MAX_SIZE) quotient bits (5 at MAX_SIZE = 20),
// one quotient bit per cycle in the restoring divider.
// Each result shows for one cycle only; busy drops as the last result is
// registered, so the next request may overlap its strobe.
// Reset clears the controller state and the result strobe.
// ---------------------------------------------------------------------------
module permutation_unrank_unit #(
    parameter int MAX_SIZE = 20
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [pu_pkg::SIZE_W-1:0] size,
    input  logic [pu_pkg::RANK_W-1:0] rank,
    output logic                      strobe,
    output logic [pu_pkg::ELEM_W-1:0] element,
    output logic                      last,
    output logic                      error
);

    pu_pkg::cmd_t    cmd;
    pu_pkg::status_t status;

    pu_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    pu_datapath #(
        .MAX_SIZE (MAX_SIZE)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .size    (size),
        .rank    (rank),
        .strobe  (strobe),
        .element (element),
        .last    (last),
        .error   (error)
    );

endmodule

[tb/sv/permutation_unrank_unit_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// permutation_unrank_unit_tb
// Self-checking bench for the permutation unrank unit. Requests go in through
// start/busy. A predictor computes the expected Lehmer-code permutation
// (or the single error result) for each accepted request. Each strobed result
// is checked against the oldest pending expectation. Directed boundary and sample cases
// run first, then random requests under several sender idle rates.
// ---------------------------------------------------------------------------
module permutation_unrank_unit_tb;

    localparam int MAX_SIZE    = 20;
    localparam int CYCLE_LIMIT = 500000;
    localparam int TAIL_CYCLES = 2 + 5 * MAX_SIZE + 8;
    localparam int DRAIN_LIMIT = 4000;

    typedef struct {
        logic [pu_pkg::ELEM_W-1:0] element;
        logic                      last;
        logic                      error;
    } perm_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [pu_pkg::SIZE_W-1:0] size;
    logic [pu_pkg::RANK_W-1:0] rank;
    logic                      strobe;
    logic [pu_pkg::ELEM_W-1:0] element;
    logic                      last;
    logic                      error;

    perm_result_t pending_results[$];
    perm_result_t head;
    int           mismatch_count;
    int           cycle_count;

    permutation_unrank_unit #(
        .MAX_SIZE (MAX_SIZE)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .size    (size),
        .rank    (rank),
        .strobe  (strobe),
        .element (element),
        .last    (last),
        .error   (error)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[%0t] timeout after %0d cycles", $time, cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic longint unsigned factorial_of(input int n);
        longint unsigned f;
        f = 1;
        for (int i = 2; i <= n; i++)
            f = f * longint'(i);
        return f;
    endfunction

    function automatic longint unsigned random_word();
        return {$urandom, $urandom};
    endfunction

    // Appends one expected result at the tail of the pending queue.
    function automatic void queue_result(input perm_result_t r);
        pending_results = {pending_results, r};
    endfunction

    // Queues the results that one accepted request must produce.
    function automatic void predict_permutation(input logic [pu_pkg::SIZE_W-1:0] sz,
                                                input logic [pu_pkg::RANK_W-1:0] rk);
        logic [pu_pkg::ELEM_W-1:0] pool[MAX_SIZE];
        longint unsigned           remainder;
        longint unsigned           f;
        longint unsigned           q;
        int                        left;
        int                        pos;
        perm_result_t              r;
        if (sz == 0 || sz > MAX_SIZE || rk >= factorial_of(sz))
        begin
            r.element = '0;
            r.last    = 1'b1;
            r.error   = 1'b1;
            queue_result(r);
            return;
        end
        for (int j = 0; j < sz; j++)
            pool[j] = pu_pkg::ELEM_W'(j);
        remainder = {2'b00, rk};
        for (left = sz; left > 0; left--)
        begin
            f         = factorial_of(left - 1);
            q         = remainder / f;
            remainder = remainder % f;
            if (q >= left)
                q = longint'(left - 1);
            pos       = int'(q);
            r.element = pool[pos];
            r.last    = (left == 1);
            r.error   = 1'b0;
            queue_result(r);
            for (int j = pos; j + 1 < left; j++)
                pool[j] = pool[j + 1];
        end
    endfunction

    // Holds the request until accepted; start stays high on return.
    task automatic send_request(input logic [pu_pkg::SIZE_W-1:0] sz,
                                input logic [pu_pkg::RANK_W-1:0] rk);
        @(negedge clk);
        start <= 1'b1;
        size  <= sz;
        rank  <= rk;
        do
            @(posedge clk);
        while (busy);
        predict_permutation(sz, rk);
    endtask

    task automatic sender_gap(input int idle_pct);
        int gap;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            // mostly short gaps, some long enough to outlast a full request
            gap = ($urandom_range(3) == 0) ? $urandom_range(1, 110) : $urandom_range(1, 8);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result element=%0d last=%0b error=%0b",
                                          element, last, error));
            else
            begin
                head = pending_results.pop_front();
                if (element !== head.element)
                    report_mismatch($sformatf("element got %0d want %0d",
                                              element, head.element));
                if (last !== head.last)
                    report_mismatch($sformatf("last got %0b want %0b", last, head.last));
                if (error !== head.error)
                    report_mismatch($sformatf("error got %0b want %0b", error, head.error));
            end
        end
    end

    task automatic test_rejected_sizes();
        send_request(5'd0, '0);
        send_request(5'd31, '1);
        send_request(5'(MAX_SIZE + 1), '0);
    endtask

    // last permutation of each size and the first rank past it
    task automatic test_rank_boundaries();
        int sizes[4] = '{1, 2, 3, MAX_SIZE};
        foreach (sizes[i])
        begin
            send_request(pu_pkg::SIZE_W'(sizes[i]),
                         pu_pkg::RANK_W'(factorial_of(sizes[i]) - 1));
            send_request(pu_pkg::SIZE_W'(sizes[i]),
                         pu_pkg::RANK_W'(factorial_of(sizes[i])));
        end
        send_request(5'(MAX_SIZE), '1);
    endtask

    task automatic test_sample_permutations();
        send_request(5'd1, '0);
        send_request(5'(MAX_SIZE), '0);
        send_request(5'd19, pu_pkg::RANK_W'(factorial_of(19) - 1));
        send_request(5'd4, 62'd13);
        send_request(5'd5, 62'd119);
        send_request(5'd12, pu_pkg::RANK_W'(random_word() % factorial_of(12)));
    endtask

    task automatic test_random_requests(input int count, input int idle_pct);
        int                        kind;
        logic [pu_pkg::SIZE_W-1:0] sz;
        logic [pu_pkg::RANK_W-1:0] rk;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(99);
            if (kind < 80)
            begin
                sz = pu_pkg::SIZE_W'($urandom_range(1, MAX_SIZE));
                rk = pu_pkg::RANK_W'(random_word() % factorial_of(sz));
            end
            else if (kind < 90)
            begin
                sz = pu_pkg::SIZE_W'($urandom_range(1, MAX_SIZE));
                rk = pu_pkg::RANK_W'(factorial_of(sz) - 1 + $urandom_range(0, 2));
            end
            else
            begin
                sz = pu_pkg::SIZE_W'($urandom);
                rk = pu_pkg::RANK_W'(random_word());
            end
            send_request(sz, rk);
            sender_gap(idle_pct);
        end
    endtask

    initial
    begin
        int waited;
        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        size           = '0;
        rank           = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_rejected_sizes();
        test_rank_boundaries();
        test_sample_permutations();
        test_random_requests(130, 0);
        test_random_requests(125, 61);
        test_random_requests(125, 16);

        @(negedge clk);
        start <= 1'b0;

        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
